@@ rtl/core/tnpc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tnpc_pkg;

    localparam int NEAR_W   = 31;
    localparam int MARGIN_W = 16;
    localparam int CFG_IDX_W = 1;

    // register indexes on the config port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NEAR_PLANE_Z  = 1'b0,
        CFG_INSIDE_MARGIN = 1'b1
    } cfg_idx_t;

    localparam logic [NEAR_W-1:0]   NEAR_RESET   = 31'd6554;
    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 16'd66;

endpackage

`default_nettype wire

@@ rtl/core/triangle_near_plane_clipper.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake              Payload
// in        sink       in_valid / in_stall    v0_x .. v2_z
// out       source     out_valid / out_stall  tri_a_x .. tri_c_z, last_of_run
// cfg       sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Input triangles pass through the crossing divider, one quotient bit per stage,
// and the fan output register before the first triangle goes out.
// One triangle enters per cycle while the output is not stalled; a triangle
// clipped to a quad holds the pipeline while its second fan triangle goes out.
// Culled or fully clipped inputs produce no transfer. cfg_ready is always high.
// Reset clears valid bits and loads the register defaults; a stalled triangle
// in the output register freezes every stage, so nothing is lost or repeated.
module triangle_near_plane_clipper #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tnpc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tnpc_pkg::NEAR_W-1:0]          cfg_data,
    // input triangle
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [COORD_WIDTH-1:0]        v0_x,
    input  logic signed [COORD_WIDTH-1:0]        v0_y,
    input  logic signed [COORD_WIDTH-1:0]        v0_z,
    input  logic signed [COORD_WIDTH-1:0]        v1_x,
    input  logic signed [COORD_WIDTH-1:0]        v1_y,
    input  logic signed [COORD_WIDTH-1:0]        v1_z,
    input  logic signed [COORD_WIDTH-1:0]        v2_x,
    input  logic signed [COORD_WIDTH-1:0]        v2_y,
    input  logic signed [COORD_WIDTH-1:0]        v2_z,
    // output triangles
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [COORD_WIDTH-1:0]        tri_a_x,
    output logic signed [COORD_WIDTH-1:0]        tri_a_y,
    output logic signed [COORD_WIDTH-1:0]        tri_a_z,
    output logic signed [COORD_WIDTH-1:0]        tri_b_x,
    output logic signed [COORD_WIDTH-1:0]        tri_b_y,
    output logic signed [COORD_WIDTH-1:0]        tri_b_z,
    output logic signed [COORD_WIDTH-1:0]        tri_c_x,
    output logic signed [COORD_WIDTH-1:0]        tri_c_y,
    output logic signed [COORD_WIDTH-1:0]        tri_c_z,
    output logic                                 last_of_run
);

    localparam int W    = COORD_WIDTH;
    localparam int NW   = tnpc_pkg::NEAR_W;
    // wide enough for any z and near + margin
    localparam int NZW  = ((W > 32) ? W : 32) + 1;
    localparam int LDIV = W + 5;
    localparam int LDET = 5;
    localparam int BW   = 1 + 3 + 9 * W;
    localparam logic [NZW-1:0] ZMAX = NZW'({(W-1){1'b1}});

    logic [NW-1:0]                    near_reg;
    logic [tnpc_pkg::MARGIN_W-1:0]    margin_reg;

    logic                adv;
    logic [NW:0]         thr;
    logic [2:0]          ins;
    logic [BW-1:0]       bundle_in;
    logic [BW-1:0]       bundle_out;
    logic                det_neg;
    logic                det_neg_d;
    logic signed [W-1:0] vin [3][3];    // [vertex][axis]
    logic signed [W-1:0] vx [3];
    logic signed [W-1:0] vy [3];
    logic signed [W-1:0] vz [3];
    logic signed [W-1:0] cx [3];
    logic signed [W-1:0] cy [3];
    logic signed [W-1:0] czc;
    logic [NZW-1:0]      near_ext;

    // ---------------------------------------------------------------
    // Configuration registers; the block does not enforce that writes arrive only while idle
    // ---------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_reg   <= tnpc_pkg::NEAR_RESET;
            margin_reg <= tnpc_pkg::MARGIN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                tnpc_pkg::CFG_NEAR_PLANE_Z:  near_reg   <= cfg_data;
                tnpc_pkg::CFG_INSIDE_MARGIN: margin_reg <= cfg_data[tnpc_pkg::MARGIN_W-1:0];
                default: ;
            endcase
        end
    end

    // whole pipeline moves together; only the fan register can hold it
    assign in_stall = !adv;

    // ---------------------------------------------------------------
    // Inside test at entry: z > near + margin
    // ---------------------------------------------------------------
    assign thr = (NW+1)'(near_reg) + (NW+1)'(margin_reg);

    assign vin[0][0] = v0_x;  assign vin[0][1] = v0_y;  assign vin[0][2] = v0_z;
    assign vin[1][0] = v1_x;  assign vin[1][1] = v1_y;  assign vin[1][2] = v1_z;
    assign vin[2][0] = v2_x;  assign vin[2][1] = v2_y;  assign vin[2][2] = v2_z;

    for (genvar i = 0; i < 3; i++)
    begin : g_ins
        assign ins[i] = (NZW+1)'(vin[i][2]) > $signed((NZW+1)'(thr));
    end

    // vertices and flags ride alongside the divider pipeline
    assign bundle_in = {in_valid, ins,
                        v2_z, v2_y, v2_x, v1_z, v1_y, v1_x, v0_z, v0_y, v0_x};

    tnpc_dly #(
        .WIDTH (BW),
        .DEPTH (LDIV)
    ) u_vdly (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv),
        .din   (bundle_in),
        .dout  (bundle_out)
    );

    for (genvar i = 0; i < 3; i++)
    begin : g_unpack
        assign vx[i] = bundle_out[(3*i)*W +: W];
        assign vy[i] = bundle_out[(3*i+1)*W +: W];
        assign vz[i] = bundle_out[(3*i+2)*W +: W];
    end

    // ---------------------------------------------------------------
    // Back-face cull: sign of the triple product
    // ---------------------------------------------------------------
    tnpc_det #(
        .W (W)
    ) u_det (
        .clk     (clk),
        .en      (adv),
        .v0_x    (v0_x),
        .v0_y    (v0_y),
        .v0_z    (v0_z),
        .v1_x    (v1_x),
        .v1_y    (v1_y),
        .v1_z    (v1_z),
        .v2_x    (v2_x),
        .v2_y    (v2_y),
        .v2_z    (v2_z),
        .det_neg (det_neg)
    );

    tnpc_dly #(
        .WIDTH (1),
        .DEPTH (LDIV - LDET)
    ) u_ddly (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv),
        .din   (det_neg),
        .dout  (det_neg_d)
    );

    // ---------------------------------------------------------------
    // Edge crossings. Edge i runs from vertex i-1 to vertex i; all three
    // are computed, the fan keeps only those whose ends straddle the plane.
    // ---------------------------------------------------------------
    for (genvar i = 0; i < 3; i++)
    begin : g_edge
        localparam int P = (i == 0) ? 2 : i - 1;

        tnpc_div #(
            .W   (W),
            .NZW (NZW)
        ) u_div_x (
            .clk  (clk),
            .en   (adv),
            .pa   (vin[P][0]),
            .ca   (vin[i][0]),
            .pz   (vin[P][2]),
            .cz   (vin[i][2]),
            .near (near_reg),
            .res  (cx[i])
        );

        tnpc_div #(
            .W   (W),
            .NZW (NZW)
        ) u_div_y (
            .clk  (clk),
            .en   (adv),
            .pa   (vin[P][1]),
            .ca   (vin[i][1]),
            .pz   (vin[P][2]),
            .cz   (vin[i][2]),
            .near (near_reg),
            .res  (cy[i])
        );
    end

    // crossing depth is the near plane, clamped to the coordinate range
    assign near_ext = NZW'(near_reg);
    assign czc = (near_ext > ZMAX) ? ZMAX[W-1:0] : near_ext[W-1:0];

    // ---------------------------------------------------------------
    // Fan assembly and output register
    // ---------------------------------------------------------------
    tnpc_fan #(
        .W (W)
    ) u_fan (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_vld      (bundle_out[BW-1]),
        .det_neg     (det_neg_d),
        .ins         (bundle_out[BW-2 -: 3]),
        .vx          (vx),
        .vy          (vy),
        .vz          (vz),
        .cx          (cx),
        .cy          (cy),
        .cz          (czc),
        .adv         (adv),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .tri_a_x     (tri_a_x),
        .tri_a_y     (tri_a_y),
        .tri_a_z     (tri_a_z),
        .tri_b_x     (tri_b_x),
        .tri_b_y     (tri_b_y),
        .tri_b_z     (tri_b_z),
        .tri_c_x     (tri_c_x),
        .tri_c_y     (tri_c_y),
        .tri_c_z     (tri_c_z),
        .last_of_run (last_of_run)
    );

endmodule

`default_nettype wire

@@ rtl/core/tnpc_dly.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Enabled shift line, DEPTH stages.
module tnpc_dly #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] sr_reg [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                sr_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            sr_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                sr_reg[i] <= sr_reg[i-1];
            end
        end
    end

    assign dout = sr_reg[DEPTH-1];

endmodule

`default_nettype wire

@@ rtl/core/tnpc_det.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Sign of det[v0;v1;v2], exact. Five register stages.
module tnpc_det #(
    parameter int W = 32
) (
    input  logic                clk,
    input  logic                en,
    input  logic signed [W-1:0] v0_x,
    input  logic signed [W-1:0] v0_y,
    input  logic signed [W-1:0] v0_z,
    input  logic signed [W-1:0] v1_x,
    input  logic signed [W-1:0] v1_y,
    input  logic signed [W-1:0] v1_z,
    input  logic signed [W-1:0] v2_x,
    input  logic signed [W-1:0] v2_y,
    input  logic signed [W-1:0] v2_z,
    output logic                det_neg
);

    localparam int PW = 2 * W;
    localparam int MW = 2 * W + 1;
    localparam int LW = 2 * W + 1;
    localparam int TW = 3 * W + 3;

    logic signed [PW-1:0] p_reg [6];
    logic signed [W-1:0]  a1_reg [3];
    logic signed [MW-1:0] m_reg [3];
    logic signed [W-1:0]  a2_reg [3];
    logic signed [LW-1:0] lo_reg [3];
    logic signed [LW-1:0] hi_reg [3];
    logic signed [TW-1:0] t_reg [3];
    logic                 neg_reg;

    logic signed [TW-1:0] det;

    // stage 1: 2x2 minor products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0] <= PW'(v1_y) * PW'(v2_z);
            p_reg[1] <= PW'(v1_z) * PW'(v2_y);
            p_reg[2] <= PW'(v1_x) * PW'(v2_z);
            p_reg[3] <= PW'(v1_z) * PW'(v2_x);
            p_reg[4] <= PW'(v1_x) * PW'(v2_y);
            p_reg[5] <= PW'(v1_y) * PW'(v2_x);
            a1_reg[0] <= v0_x;
            a1_reg[1] <= v0_y;
            a1_reg[2] <= v0_z;
        end
    end

    // stage 2: minors
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                m_reg[k]  <= MW'(p_reg[2*k]) - MW'(p_reg[2*k+1]);
                a2_reg[k] <= a1_reg[k];
            end
        end
    end

    // stage 3: v0 times minor, split into low and high halves
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                lo_reg[k] <= LW'(a2_reg[k]) * LW'($signed({1'b0, m_reg[k][W-1:0]}));
                hi_reg[k] <= LW'(a2_reg[k]) * LW'($signed(m_reg[k][MW-1:W]));
            end
        end
    end

    // stage 4: recombine halves
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                t_reg[k] <= (TW'(hi_reg[k]) <<< W) + TW'(lo_reg[k]);
            end
        end
    end

    // stage 5: cofactor sum
    assign det = t_reg[0] - t_reg[1] + t_reg[2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg <= det[TW-1];
        end
    end

    assign det_neg = neg_reg;

endmodule

`default_nettype wire

@@ rtl/core/tnpc_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

// One crossing coordinate: pa + trunc((pz-near)*(ca-pa)/(pz-cz)), clamped.
// Restoring division, one quotient bit per stage.
module tnpc_div #(
    parameter int W   = 32,
    parameter int NZW = 33
) (
    input  logic                            clk,
    input  logic                            en,
    input  logic signed [W-1:0]             pa,
    input  logic signed [W-1:0]             ca,
    input  logic signed [W-1:0]             pz,
    input  logic signed [W-1:0]             cz,
    input  logic [tnpc_pkg::NEAR_W-1:0]     near,
    output logic signed [W-1:0]             res
);

    localparam int NUMW = NZW + W + 1;
    localparam int MAGW = NZW + W;
    localparam int SW   = W + 2;
    localparam logic signed [SW-1:0] HI = SW'({1'b0, {(W-1){1'b1}}});
    localparam logic signed [SW-1:0] LO = -HI - SW'(1);

    // stage A
    logic signed [NZW-1:0]  nz_reg;
    logic signed [W:0]      d_reg;
    logic signed [W:0]      dz_reg;
    logic signed [W-1:0]    pa_a_reg;
    // stage B
    logic signed [NUMW-1:0] num_reg;
    logic                   dneg_reg;
    logic [W:0]             dmag_b_reg;
    logic signed [W-1:0]    pa_b_reg;
    // stage C
    logic [MAGW-1:0]        mag_reg;
    logic                   neg_c_reg;
    logic [W:0]             dmag_c_reg;
    logic signed [W-1:0]    pa_c_reg;
    // stage D and divide steps
    logic [W:0]             rem_reg  [W+1];
    logic [W-1:0]           q_reg    [W+1];
    logic [W-1:0]           nl_reg   [W+1];
    logic [W:0]             dmag_reg [W+1];
    logic                   neg_reg  [W+1];
    logic                   big_reg  [W+1];
    logic signed [W-1:0]    pa_reg   [W+1];
    // stage E
    logic signed [W-1:0]    res_reg;

    logic [NZW-1:0]         hi_part;
    logic signed [SW-1:0]   sum;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nz_reg   <= NZW'(pz) - $signed(NZW'(near));
            d_reg    <= (W+1)'(ca) - (W+1)'(pa);
            dz_reg   <= (W+1)'(pz) - (W+1)'(cz);
            pa_a_reg <= pa;

            num_reg    <= NUMW'(nz_reg) * NUMW'(d_reg);
            dneg_reg   <= dz_reg[W];
            dmag_b_reg <= dz_reg[W] ? (W+1)'(-dz_reg) : (W+1)'(dz_reg);
            pa_b_reg   <= pa_a_reg;

            mag_reg    <= num_reg[NUMW-1] ? MAGW'(-num_reg) : MAGW'(num_reg);
            neg_c_reg  <= num_reg[NUMW-1] ^ dneg_reg;
            dmag_c_reg <= dmag_b_reg;
            pa_c_reg   <= pa_b_reg;
        end
    end

    assign hi_part = mag_reg[MAGW-1:W];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            big_reg[0]  <= hi_part >= NZW'(dmag_c_reg);
            rem_reg[0]  <= hi_part[W:0];
            q_reg[0]    <= '0;
            nl_reg[0]   <= mag_reg[W-1:0];
            dmag_reg[0] <= dmag_c_reg;
            neg_reg[0]  <= neg_c_reg;
            pa_reg[0]   <= pa_c_reg;
        end
    end

    for (genvar s = 0; s < W; s++)
    begin : g_step
        logic [W+1:0] trial;
        logic         ge;

        assign trial = {rem_reg[s], nl_reg[s][W-1]};
        assign ge    = trial >= (W+2)'(dmag_reg[s]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s+1]  <= ge ? (W+1)'(trial - (W+2)'(dmag_reg[s])) : trial[W:0];
                q_reg[s+1]    <= {q_reg[s][W-2:0], ge};
                nl_reg[s+1]   <= {nl_reg[s][W-2:0], 1'b0};
                dmag_reg[s+1] <= dmag_reg[s];
                neg_reg[s+1]  <= neg_reg[s];
                big_reg[s+1]  <= big_reg[s];
                pa_reg[s+1]   <= pa_reg[s];
            end
        end
    end

    assign sum = neg_reg[W] ? SW'(pa_reg[W]) - $signed({2'b00, q_reg[W]})
                            : SW'(pa_reg[W]) + $signed({2'b00, q_reg[W]});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (big_reg[W])
            begin
                res_reg <= neg_reg[W] ? LO[W-1:0] : HI[W-1:0];
            end
            else if (sum > HI)
            begin
                res_reg <= HI[W-1:0];
            end
            else if (sum < LO)
            begin
                res_reg <= LO[W-1:0];
            end
            else
            begin
                res_reg <= sum[W-1:0];
            end
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

@@ rtl/core/tnpc_fan.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Polygon assembly and fan output register; emits zero, one or two triangles.
module tnpc_fan #(
    parameter int W = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_vld,
    input  logic                det_neg,
    input  logic [2:0]          ins,
    input  logic signed [W-1:0] vx [3],
    input  logic signed [W-1:0] vy [3],
    input  logic signed [W-1:0] vz [3],
    input  logic signed [W-1:0] cx [3],
    input  logic signed [W-1:0] cy [3],
    input  logic signed [W-1:0] cz,
    output logic                adv,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [W-1:0] tri_a_x,
    output logic signed [W-1:0] tri_a_y,
    output logic signed [W-1:0] tri_a_z,
    output logic signed [W-1:0] tri_b_x,
    output logic signed [W-1:0] tri_b_y,
    output logic signed [W-1:0] tri_b_z,
    output logic signed [W-1:0] tri_c_x,
    output logic signed [W-1:0] tri_c_y,
    output logic signed [W-1:0] tri_c_z,
    output logic                last_of_run
);

    logic signed [W-1:0] px [4];
    logic signed [W-1:0] py [4];
    logic signed [W-1:0] pz [4];
    logic [2:0]          n;
    logic [1:0]          ntri;

    logic signed [W-1:0] px_reg [4];
    logic signed [W-1:0] py_reg [4];
    logic signed [W-1:0] pz_reg [4];
    logic [1:0]          ntri_reg;
    logic                phase_reg;
    logic                fvalid_reg;
    logic                last;

    always_comb
    begin
        n = '0;
        for (int k = 0; k < 4; k++)
        begin
            px[k] = '0;
            py[k] = '0;
            pz[k] = '0;
        end
        for (int i = 0; i < 3; i++)
        begin
            // edge from previous vertex into vertex i
            if (ins[(i == 0) ? 2 : i - 1] != ins[i])
            begin
                px[n[1:0]] = cx[i];
                py[n[1:0]] = cy[i];
                pz[n[1:0]] = cz;
                n = n + 3'd1;
            end
            if (ins[i])
            begin
                px[n[1:0]] = vx[i];
                py[n[1:0]] = vy[i];
                pz[n[1:0]] = vz[i];
                n = n + 3'd1;
            end
        end
        if (!det_neg || n < 3'd3)
        begin
            ntri = 2'd0;
        end
        else
        begin
            ntri = (n == 3'd4) ? 2'd2 : 2'd1;
        end
    end

    assign last      = (ntri_reg == 2'd2) ? phase_reg : 1'b1;
    assign adv       = !fvalid_reg || (!out_stall && last);
    assign out_valid = fvalid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fvalid_reg <= 1'b0;
            ntri_reg   <= '0;
            phase_reg  <= 1'b0;
        end
        else if (adv)
        begin
            fvalid_reg <= in_vld && (ntri != 2'd0);
            ntri_reg   <= ntri;
            phase_reg  <= 1'b0;
        end
        else if (!out_stall)
        begin
            phase_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg <= px;
            py_reg <= py;
            pz_reg <= pz;
        end
    end

    assign tri_a_x = px_reg[0];
    assign tri_a_y = py_reg[0];
    assign tri_a_z = pz_reg[0];
    assign tri_b_x = phase_reg ? px_reg[2] : px_reg[1];
    assign tri_b_y = phase_reg ? py_reg[2] : py_reg[1];
    assign tri_b_z = phase_reg ? pz_reg[2] : pz_reg[1];
    assign tri_c_x = phase_reg ? px_reg[3] : px_reg[2];
    assign tri_c_y = phase_reg ? py_reg[3] : py_reg[2];
    assign tri_c_z = phase_reg ? pz_reg[3] : pz_reg[2];
    assign last_of_run = last;

endmodule

`default_nettype wire

@@ rtl/core/tnpc_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tnpc_chk #(
    parameter int W = 32
) (
    input logic         clk,
    input logic         rst_n,
    input logic         in_stall,
    input logic         out_valid,
    input logic         out_stall,
    input logic [W-1:0] tri_a_x,
    input logic         last_of_run
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out_valid dropped under stall");

    // a stalled result keeps its payload (checked on tri_a_x and last_of_run)
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(tri_a_x) && $stable(last_of_run))
        else $error("output payload changed under stall");

    // input is only held back by a pending result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("in_stall without pending output");

    // first of a fan pair is followed at once by its closing triangle
    a_fan_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_run |=> out_valid && last_of_run)
        else $error("second fan triangle missing");

endmodule

bind triangle_near_plane_clipper tnpc_chk #(
    .W (COORD_WIDTH)
) u_tnpc_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .tri_a_x     (tri_a_x),
    .last_of_run (last_of_run)
);

`default_nettype wire
